FILE: sv/trng_hm_pkg.sv
// ----------------------------------------------------------------------------
// trng_hm_pkg
// shared types, register indexes and defaults for the noise health monitor
// ----------------------------------------------------------------------------
package trng_hm_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;
  localparam int TOTAL_WIDTH_DEF   = 48;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_TOT_W = 48;
  localparam int EVENT_W   = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_RCT_TRANSIENT = 3'd0;
  localparam cfg_idx_t REG_RCT_PERMANENT = 3'd1;
  localparam cfg_idx_t REG_APT_TRANSIENT = 3'd2;
  localparam cfg_idx_t REG_APT_PERMANENT = 3'd3;
  localparam cfg_idx_t REG_APT_WINDOW    = 3'd4;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] RCT_TRANSIENT_RST = 16'd31;
  localparam logic [CFG_W-1:0] RCT_PERMANENT_RST = 16'd61;
  localparam logic [CFG_W-1:0] APT_TRANSIENT_RST = 16'd589;
  localparam logic [CFG_W-1:0] APT_PERMANENT_RST = 16'd625;
  localparam logic [CFG_W-1:0] APT_WINDOW_RST    = 16'd1024;

  // item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REARM  = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] rct_transient;
    logic [CFG_W-1:0] rct_permanent;
    logic [CFG_W-1:0] apt_transient;
    logic [CFG_W-1:0] apt_permanent;
    logic [CFG_W-1:0] apt_window;
  } cfg_t;

  typedef struct packed {
    logic                 accepted;
    logic                 failed;
    logic                 dead;
    logic                 healthy;
    logic                 warmed_up;
    logic [OUT_TOT_W-1:0] bit_count;
    logic [OUT_TOT_W-1:0] one_count;
    logic [OUT_TOT_W-1:0] zero_count;
    logic [EVENT_W-1:0]   fail_events;
  } res_t;

endpackage

FILE: sv/trng_hm_core.sv
// ----------------------------------------------------------------------------
// trng_hm_core
// test state and combinational step logic for repetition count and adaptive
// proportion tests
// ----------------------------------------------------------------------------
module trng_hm_core #(
  parameter int COUNTER_WIDTH = trng_hm_pkg::COUNTER_WIDTH_DEF,
  parameter int TOTAL_WIDTH   = trng_hm_pkg::TOTAL_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic              opcode,
  input  logic              sample_bit,
  input  trng_hm_pkg::cfg_t cfg,
  output trng_hm_pkg::res_t res,
  output logic              dead_state
);
  import trng_hm_pkg::*;

  localparam int CMP_W = (COUNTER_WIDTH > CFG_W) ? COUNTER_WIDTH : CFG_W;

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;
  typedef logic [TOTAL_WIDTH-1:0]   tot_t;

  logic               run_value, run_value_next;
  cnt_t               run_length, run_length_next;
  logic               window_reference, window_reference_next;
  cnt_t               window_matches, window_matches_next;
  cnt_t               window_position, window_position_next;
  logic               warmup_flag, warmup_flag_next;
  logic               failed_latch, failed_latch_next;
  logic               dead_latch, dead_latch_next;
  tot_t               bit_total, bit_total_next;
  tot_t               ones_total, ones_total_next;
  tot_t               zeros_total, zeros_total_next;
  logic [EVENT_W-1:0] event_count, event_count_next;
  logic               acc;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic reaches(input cnt_t v, input logic [CFG_W-1:0] cut);
    return CMP_W'(v) >= CMP_W'(cut);
  endfunction

  always_comb begin
    logic live;
    logic fail_set;
    live                  = 1'b1;
    fail_set              = 1'b0;
    acc                   = 1'b1;
    run_value_next        = run_value;
    run_length_next       = run_length;
    window_reference_next = window_reference;
    window_matches_next   = window_matches;
    window_position_next  = window_position;
    warmup_flag_next      = warmup_flag;
    failed_latch_next     = failed_latch;
    dead_latch_next       = dead_latch;
    bit_total_next        = bit_total;
    ones_total_next       = ones_total;
    zeros_total_next      = zeros_total;
    event_count_next      = event_count;

    if (opcode == OP_REARM) begin
      acc = !dead_latch;
      if (!dead_latch) begin
        run_value_next        = 1'b0;
        run_length_next       = '0;
        window_reference_next = 1'b0;
        window_matches_next   = '0;
        window_position_next  = '0;
        warmup_flag_next      = 1'b0;
        failed_latch_next     = 1'b0;
      end
    end else if (dead_latch) begin
      acc = 1'b0;
    end else begin
      bit_total_next = bit_total + 1'b1;
      if (sample_bit) begin
        ones_total_next = ones_total + 1'b1;
      end else begin
        zeros_total_next = zeros_total + 1'b1;
      end

      // repetition count test
      if (run_length == '0 || sample_bit != run_value) begin
        run_value_next  = sample_bit;
        run_length_next = cnt_t'(1);
      end else begin
        run_length_next = sat_inc(run_length);
        if (reaches(run_length_next, cfg.rct_permanent)) begin
          dead_latch_next = 1'b1;
          live            = 1'b0;
        end else if (reaches(run_length_next, cfg.rct_transient)) begin
          fail_set = 1'b1;
        end
      end

      // adaptive proportion test, skipped after a permanent trip
      if (live) begin
        if (window_position == '0) begin
          window_reference_next = sample_bit;
          window_matches_next   = cnt_t'(1);
        end else if (sample_bit == window_reference) begin
          window_matches_next = sat_inc(window_matches);
          if (reaches(window_matches_next, cfg.apt_permanent)) begin
            dead_latch_next = 1'b1;
            live            = 1'b0;
          end else if (reaches(window_matches_next, cfg.apt_transient)) begin
            fail_set = 1'b1;
          end
        end
      end

      // one transient event per latch, even if both tests trip at once
      if (fail_set && !failed_latch) begin
        failed_latch_next = 1'b1;
        event_count_next  = event_count + 1'b1;
      end

      if (live) begin
        window_position_next = sat_inc(window_position);
        if (reaches(window_position_next, cfg.apt_window)) begin
          window_position_next = '0;
          if (!failed_latch_next) begin
            warmup_flag_next = 1'b1;
          end
        end
      end

      acc = live;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_value        <= 1'b0;
      run_length       <= '0;
      window_reference <= 1'b0;
      window_matches   <= '0;
      window_position  <= '0;
      warmup_flag      <= 1'b0;
      failed_latch     <= 1'b0;
      dead_latch       <= 1'b0;
      bit_total        <= '0;
      ones_total       <= '0;
      zeros_total      <= '0;
      event_count      <= '0;
    end else if (go) begin
      run_value        <= run_value_next;
      run_length       <= run_length_next;
      window_reference <= window_reference_next;
      window_matches   <= window_matches_next;
      window_position  <= window_position_next;
      warmup_flag      <= warmup_flag_next;
      failed_latch     <= failed_latch_next;
      dead_latch       <= dead_latch_next;
      bit_total        <= bit_total_next;
      ones_total       <= ones_total_next;
      zeros_total      <= zeros_total_next;
      event_count      <= event_count_next;
    end
  end

  always_comb begin
    res.accepted    = acc;
    res.failed      = failed_latch_next;
    res.dead        = dead_latch_next;
    res.healthy     = warmup_flag_next && !failed_latch_next && !dead_latch_next;
    res.warmed_up   = warmup_flag_next;
    res.bit_count   = OUT_TOT_W'(bit_total_next);
    res.one_count   = OUT_TOT_W'(ones_total_next);
    res.zero_count  = OUT_TOT_W'(zeros_total_next);
    res.fail_events = event_count_next;
  end

  assign dead_state = dead_latch;

endmodule

FILE: sv/trng_rct_apt_health_monitor.sv
// ----------------------------------------------------------------------------
// trng_rct_apt_health_monitor
// repetition count and adaptive proportion health tests on a raw noise bit
// stream, with transient and permanent cutoffs and running totals
// ----------------------------------------------------------------------------
//
//  channel   handshake                    payload
//  -------   ---------------------------  --------------------------------------
//  item      item_valid / item_stall      opcode, sample_bit
//  result    result_valid / result_stall  accepted, failed, dead, healthy,
//                                         warmed_up, bit_count, one_count,
//                                         zero_count, fail_events
//  config    cfg_valid / cfg_ready        cfg_index, cfg_data
//
//  one item per cycle sustained while result_stall is low; an accepted item
//  passes the input register, then step logic into the result register
//  the step logic is a single increment and its cutoff compares per counter, so the test
//  state feeds back into the very next item without a bubble
//  rst is synchronous: clears all test state and totals, loads default cutoffs
//  result_stall holds the result register, which in turn holds the input
//  register; item_stall rises only when both are full and the result is stalled
//  cfg_ready is always high; the user, not the block, sees that registers are written only while idle
// ----------------------------------------------------------------------------
module trng_rct_apt_health_monitor #(
  parameter int COUNTER_WIDTH = trng_hm_pkg::COUNTER_WIDTH_DEF,
  parameter int TOTAL_WIDTH   = trng_hm_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // item channel
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic                                   opcode,
  input  logic                                   sample_bit,
  // result channel
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic                                   accepted,
  output logic                                   failed,
  output logic                                   dead,
  output logic                                   healthy,
  output logic                                   warmed_up,
  output logic [trng_hm_pkg::OUT_TOT_W-1:0]      bit_count,
  output logic [trng_hm_pkg::OUT_TOT_W-1:0]      one_count,
  output logic [trng_hm_pkg::OUT_TOT_W-1:0]      zero_count,
  output logic [trng_hm_pkg::EVENT_W-1:0]        fail_events,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  trng_hm_pkg::cfg_idx_t                  cfg_index,
  input  logic [trng_hm_pkg::CFG_W-1:0]          cfg_data
);
  import trng_hm_pkg::*;

  cfg_t cfg;
  logic in_full;     // input register holds an item
  logic in_opcode;
  logic in_bit;
  logic res_full;    // result register holds a result
  res_t res;
  res_t step_res;
  logic advance;     // result register can take a new value
  logic go;          // step the tests this cycle
  logic dead_state;

  // configuration registers, never busy
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rct_transient <= RCT_TRANSIENT_RST;
      cfg.rct_permanent <= RCT_PERMANENT_RST;
      cfg.apt_transient <= APT_TRANSIENT_RST;
      cfg.apt_permanent <= APT_PERMANENT_RST;
      cfg.apt_window    <= APT_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RCT_TRANSIENT: cfg.rct_transient <= cfg_data;
        REG_RCT_PERMANENT: cfg.rct_permanent <= cfg_data;
        REG_APT_TRANSIENT: cfg.apt_transient <= cfg_data;
        REG_APT_PERMANENT: cfg.apt_permanent <= cfg_data;
        REG_APT_WINDOW:    cfg.apt_window    <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // two-register pipe: input register, then result register
  assign advance    = !res_full || !result_stall;
  assign go         = in_full && advance;
  assign item_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_opcode <= opcode;
      in_bit    <= sample_bit;
    end
  end

  // test state and step logic
  trng_hm_core #(
    .COUNTER_WIDTH (COUNTER_WIDTH),
    .TOTAL_WIDTH   (TOTAL_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .opcode     (in_opcode),
    .sample_bit (in_bit),
    .cfg        (cfg),
    .res        (step_res),
    .dead_state (dead_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res <= step_res;
    end
  end

  assign result_valid = res_full;
  assign accepted     = res.accepted;
  assign failed       = res.failed;
  assign dead         = res.dead;
  assign healthy      = res.healthy;
  assign warmed_up    = res.warmed_up;
  assign bit_count    = res.bit_count;
  assign one_count    = res.one_count;
  assign zero_count   = res.zero_count;
  assign fail_events  = res.fail_events;

  // dead never clears outside reset
  a_dead_sticky : assert property (@(posedge clk) disable iff (rst)
    dead_state |=> dead_state)
    else $error("dead latch cleared without reset");

  // any item stepped while dead yields an unaccepted, dead result
  a_dead_rejects : assert property (@(posedge clk) disable iff (rst)
    go && dead_state |=> res_full && !res.accepted && res.dead)
    else $error("item accepted while dead");

  // a held input item keeps its payload until the step consumes it
  a_in_hold : assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_opcode) && $stable(in_bit))
    else $error("input register lost a waiting item");

endmodule

FILE: dv/trng_rct_apt_health_monitor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trng_rct_apt_health_monitor_test
// self-checking bench for the repetition count / adaptive proportion monitor:
// a directed table covers reset state, cutoff extremes, window shrink and
// re-arm, then random run-shaped bit streams run under changing cutoffs, and
// a closing table drives the monitor into its dead state; every result is
// compared field by field against a hand-derived value or an in-bench prediction of the tests
// ----------------------------------------------------------------------------
module trng_rct_apt_health_monitor_test;
  import trng_hm_pkg::*;

  localparam int CNT_W         = COUNTER_WIDTH_DEF;
  localparam int TOT_W         = TOTAL_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 75;
  localparam int REPORT_LIMIT  = 10;
  localparam int RUN_LIMIT_NS  = 2_000_000;

  // indexes the block has no register behind
  localparam cfg_idx_t REG_SPARE_LO = 3'd5;
  localparam cfg_idx_t REG_SPARE_HI = 3'd7;

  // tracked state of both health tests and the running totals
  typedef struct packed {
    logic             run_bit;
    logic [CNT_W-1:0] run_len;
    logic             win_ref;
    logic [CNT_W-1:0] win_hits;
    logic [CNT_W-1:0] win_pos;
    logic             warm;
    logic             failed;
    logic             dead;
    logic [TOT_W-1:0] n_bits;
    logic [TOT_W-1:0] n_ones;
    logic [TOT_W-1:0] n_zeros;
    logic [EVENT_W-1:0] n_transient;
  } health_state_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_REARM, ROW_WRITE} row_kind_t;

  // one line of the directed stimulus; typed rows carry a hand-derived result
  typedef struct packed {
    row_kind_t        kind;
    logic             smp_val;
    cfg_idx_t         idx;
    logic [CFG_W-1:0] data;
    logic             typed;
    res_t             want;
  } plan_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block ports, all inputs known from time zero
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic                 opcode = OP_SAMPLE;
  logic                 sample_bit = 1'b0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 accepted;
  logic                 failed;
  logic                 dead;
  logic                 healthy;
  logic                 warmed_up;
  logic [OUT_TOT_W-1:0] bit_count;
  logic [OUT_TOT_W-1:0] one_count;
  logic [OUT_TOT_W-1:0] zero_count;
  logic [EVENT_W-1:0]   fail_events;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_idx_t             cfg_index = REG_RCT_TRANSIENT;
  logic [CFG_W-1:0]     cfg_data = '0;

  trng_rct_apt_health_monitor #(
    .COUNTER_WIDTH(CNT_W),
    .TOTAL_WIDTH  (TOT_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .opcode      (opcode),
    .sample_bit  (sample_bit),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .accepted    (accepted),
    .failed      (failed),
    .dead        (dead),
    .healthy     (healthy),
    .warmed_up   (warmed_up),
    .bit_count   (bit_count),
    .one_count   (one_count),
    .zero_count  (zero_count),
    .fail_events (fail_events),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // bench-side copy of the cutoffs and the test state
  cfg_t          limits;
  health_state_t tracked;
  res_t          awaited_status[$];
  plan_row_t     opening_plan[$];
  plan_row_t     closing_plan[$];

  int   fault_count  = 0;
  int   items_sent   = 0;
  int   results_seen = 0;
  int   stall_left   = 0;
  int   pause_len;
  res_t observed;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // run, match and position counters stick at all ones
  function automatic logic [CNT_W-1:0] sat_up(logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // a transient event is counted only on the rising edge of the latch
  function automatic void latch_transient(inout health_state_t st);
    if (!st.failed) begin
      st.failed      = 1'b1;
      st.n_transient = st.n_transient + 1'b1;
    end
  endfunction

  function automatic res_t advance_health(inout health_state_t st, input logic op,
                                          input logic smp_val);
    res_t r;
    logic live;
    live = 1'b0;
    if (op == OP_REARM) begin
      // re-arm clears both tests, warmup and failed, unless dead
      live = !st.dead;
      if (live) begin
        st.run_bit  = 1'b0;
        st.run_len  = '0;
        st.win_ref  = 1'b0;
        st.win_hits = '0;
        st.win_pos  = '0;
        st.warm     = 1'b0;
        st.failed   = 1'b0;
      end
    end else if (!st.dead) begin
      live       = 1'b1;
      st.n_bits  = st.n_bits + 1'b1;
      if (smp_val)
        st.n_ones = st.n_ones + 1'b1;
      else
        st.n_zeros = st.n_zeros + 1'b1;
      // repetition count: only a repeated bit can trip
      if (st.run_len == '0 || smp_val != st.run_bit) begin
        st.run_bit = smp_val;
        st.run_len = CNT_W'(1);
      end else begin
        st.run_len = sat_up(st.run_len);
        if (st.run_len >= limits.rct_permanent) begin
          st.dead = 1'b1;
          live    = 1'b0;
        end else if (st.run_len >= limits.rct_transient) begin
          latch_transient(st);
        end
      end
      // adaptive proportion: only a match after the window's first bit can trip
      if (live) begin
        if (st.win_pos == '0) begin
          st.win_ref  = smp_val;
          st.win_hits = CNT_W'(1);
        end else if (smp_val == st.win_ref) begin
          st.win_hits = sat_up(st.win_hits);
          if (st.win_hits >= limits.apt_permanent) begin
            st.dead = 1'b1;
            live    = 1'b0;
          end else if (st.win_hits >= limits.apt_transient) begin
            latch_transient(st);
          end
        end
      end
      // window close; a clean window completes warmup
      if (live) begin
        st.win_pos = sat_up(st.win_pos);
        if (st.win_pos >= limits.apt_window) begin
          st.win_pos = '0;
          if (!st.failed)
            st.warm = 1'b1;
        end
      end
    end
    r.accepted    = live;
    r.failed      = st.failed;
    r.dead        = st.dead;
    r.healthy     = st.warm && !st.failed && !st.dead;
    r.warmed_up   = st.warm;
    r.bit_count   = st.n_bits[OUT_TOT_W-1:0];
    r.one_count   = st.n_ones[OUT_TOT_W-1:0];
    r.zero_count  = st.n_zeros[OUT_TOT_W-1:0];
    r.fail_events = st.n_transient;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table rows
  // ---------------------------------------------------------------------------

  function automatic res_t outcome(logic acc, logic fl, logic dd, logic ok, logic wm,
                                   logic [OUT_TOT_W-1:0] nb, logic [OUT_TOT_W-1:0] no,
                                   logic [OUT_TOT_W-1:0] nz, logic [EVENT_W-1:0] nt);
    res_t r;
    r = {acc, fl, dd, ok, wm, nb, no, nz, nt};
    return r;
  endfunction

  function automatic plan_row_t checked_row(row_kind_t kind, logic smp_val, res_t want);
    plan_row_t row;
    row         = '0;
    row.kind    = kind;
    row.smp_val = smp_val;
    row.typed   = 1'b1;
    row.want    = want;
    return row;
  endfunction

  function automatic plan_row_t item_row(row_kind_t kind, logic smp_val);
    plan_row_t row;
    row         = '0;
    row.kind    = kind;
    row.smp_val = smp_val;
    return row;
  endfunction

  function automatic plan_row_t write_row(cfg_idx_t idx, logic [CFG_W-1:0] data);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  // mostly small cutoffs so the tests trip often, now and then an extreme
  function automatic logic [CFG_W-1:0] draw_cutoff(int lo, int hi);
    case ($urandom_range(0, 15))
      0: return '0;
      1: return CFG_W'(1);
      2: return '1;
      default: return CFG_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_fault(string what, logic [63:0] want, logic [63:0] got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display("mismatch on %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
  endtask

  task automatic check_status(res_t want, res_t got);
    if (got.accepted !== want.accepted)
      note_fault("accepted", want.accepted, got.accepted);
    if (got.failed !== want.failed)
      note_fault("failed", want.failed, got.failed);
    if (got.dead !== want.dead)
      note_fault("dead", want.dead, got.dead);
    if (got.healthy !== want.healthy)
      note_fault("healthy", want.healthy, got.healthy);
    if (got.warmed_up !== want.warmed_up)
      note_fault("warmed_up", want.warmed_up, got.warmed_up);
    if (got.bit_count !== want.bit_count)
      note_fault("bit_count", want.bit_count, got.bit_count);
    if (got.one_count !== want.one_count)
      note_fault("one_count", want.one_count, got.one_count);
    if (got.zero_count !== want.zero_count)
      note_fault("zero_count", want.zero_count, got.zero_count);
    if (got.fail_events !== want.fail_events)
      note_fault("fail_events", want.fail_events, got.fail_events);
  endtask

  // result side: check every result, then at random hold result_stall high,
  // except in a stall-free stretch in every 48 results
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (result_valid && !result_stall) begin
      observed = {accepted, failed, dead, healthy, warmed_up,
                  bit_count, one_count, zero_count, fail_events};
      if (awaited_status.size() == 0)
        note_fault("result with nothing awaited", '0, observed.bit_count);
      else
        check_status(awaited_status.pop_front(), observed);
      results_seen++;
      pause_len = (results_seen % 48 < 10) ? 0 : $urandom_range(0, 7);
      if (pause_len != 0) begin
        result_stall <= 1'b1;
        stall_left   <= pause_len - 1;
      end
    end else if (result_stall) begin
      if (stall_left == 0)
        result_stall <= 1'b0;
      else
        stall_left <= stall_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // one item, after an optional idle gap (none in a stretch of every 64);
  // valid stays up across back-to-back items
  task automatic send_item(logic op, logic smp_val, logic typed, res_t want);
    int   gap;
    res_t predicted;
    gap = (items_sent % 64 < 12) ? 0 : $urandom_range(0, 7);
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    sample_bit <= smp_val;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = advance_health(tracked, op, smp_val);
    awaited_status.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // hold off the item side until every awaited result is back
  task automatic settle_idle();
    item_valid <= 1'b0;
    cfg_valid  <= 1'b0;
    do @(posedge clk); while (awaited_status.size() != 0);
  endtask

  // register writes happen only with the block drained
  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RCT_TRANSIENT: limits.rct_transient = data;
      REG_RCT_PERMANENT: limits.rct_permanent = data;
      REG_APT_TRANSIENT: limits.apt_transient = data;
      REG_APT_PERMANENT: limits.apt_permanent = data;
      REG_APT_WINDOW:    limits.apt_window    = data;
      default: ;
    endcase
  endtask

  task automatic run_row(plan_row_t row);
    case (row.kind)
      ROW_WRITE:  write_reg(row.idx, row.data);
      ROW_SAMPLE: send_item(OP_SAMPLE, row.smp_val, row.typed, row.want);
      default:    send_item(OP_REARM, 1'($urandom_range(0, 1)), row.typed, row.want);
    endcase
  endtask

  // dead is sticky and reset happens once, so in the random part a sample
  // that would trip a permanent cutoff is swapped for a re-arm
  task automatic offer_sample(logic smp_val);
    health_state_t trial;
    trial = tracked;
    void'(advance_health(trial, OP_SAMPLE, smp_val));
    if (trial.dead)
      send_item(OP_REARM, smp_val, 1'b0, '0);
    else
      send_item(OP_SAMPLE, smp_val, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int   phase;
    int   start;
    int   style;
    int   span;
    logic b;

    limits  = {RCT_TRANSIENT_RST, RCT_PERMANENT_RST, APT_TRANSIENT_RST,
               APT_PERMANENT_RST, APT_WINDOW_RST};
    tracked = '0;

    // re-arm straight after reset, then the first samples under default cutoffs
    opening_plan.push_back(checked_row(ROW_REARM, 1'b0, outcome(1, 0, 0, 0, 0, 0, 0, 0, 0)));
    opening_plan.push_back(checked_row(ROW_SAMPLE, 1'b1, outcome(1, 0, 0, 0, 0, 1, 1, 0, 0)));
    opening_plan.push_back(checked_row(ROW_SAMPLE, 1'b0, outcome(1, 0, 0, 0, 0, 2, 1, 1, 0)));
    // writes to unused indexes must not land on a real register
    opening_plan.push_back(write_row(REG_SPARE_LO, 16'h0000));
    opening_plan.push_back(write_row(REG_SPARE_HI, 16'hffff));
    // zero window and zero run cutoff: every sample closes a window, and the
    // first bit of a run still never trips
    opening_plan.push_back(write_row(REG_APT_WINDOW, 16'h0000));
    opening_plan.push_back(write_row(REG_RCT_TRANSIENT, 16'h0000));
    opening_plan.push_back(checked_row(ROW_SAMPLE, 1'b1, outcome(1, 0, 0, 1, 1, 3, 2, 1, 0)));
    opening_plan.push_back(checked_row(ROW_SAMPLE, 1'b1, outcome(1, 1, 0, 0, 1, 4, 3, 1, 1)));
    // failed already latched, so no second transient event
    opening_plan.push_back(checked_row(ROW_SAMPLE, 1'b1, outcome(1, 1, 0, 0, 1, 5, 4, 1, 1)));
    // re-arm keeps the totals
    opening_plan.push_back(checked_row(ROW_REARM, 1'b0, outcome(1, 0, 0, 0, 0, 5, 4, 1, 1)));
    opening_plan.push_back(checked_row(ROW_SAMPLE, 1'b0, outcome(1, 0, 0, 1, 1, 6, 4, 2, 1)));
    // apt transient cutoff of one trips on the first match after the window start
    opening_plan.push_back(write_row(REG_RCT_TRANSIENT, 16'hffff));
    opening_plan.push_back(write_row(REG_RCT_PERMANENT, 16'hffff));
    opening_plan.push_back(write_row(REG_APT_TRANSIENT, 16'h0001));
    opening_plan.push_back(write_row(REG_APT_PERMANENT, 16'hffff));
    opening_plan.push_back(write_row(REG_APT_WINDOW, 16'h0004));
    opening_plan.push_back(item_row(ROW_REARM, 1'b0));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b1));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b0));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b1));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b0));
    // largest window, then shrink it mid-window: the next sample closes it
    opening_plan.push_back(write_row(REG_APT_WINDOW, 16'hffff));
    opening_plan.push_back(write_row(REG_RCT_TRANSIENT, 16'h0003));
    opening_plan.push_back(write_row(REG_APT_TRANSIENT, 16'hffff));
    opening_plan.push_back(item_row(ROW_REARM, 1'b0));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b0));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b1));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b0));
    opening_plan.push_back(write_row(REG_APT_WINDOW, 16'h0002));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b1));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b1));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b1));
    // zero apt transient cutoff: any match after the window's first bit trips
    opening_plan.push_back(item_row(ROW_REARM, 1'b0));
    opening_plan.push_back(write_row(REG_APT_TRANSIENT, 16'h0000));
    opening_plan.push_back(write_row(REG_RCT_TRANSIENT, 16'hffff));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b0));
    opening_plan.push_back(item_row(ROW_SAMPLE, 1'b0));

    // end of life: equal run cutoffs, so the permanent trip wins and failed
    // stays low; after that samples and re-arms are both refused
    closing_plan.push_back(write_row(REG_RCT_TRANSIENT, 16'h0002));
    closing_plan.push_back(write_row(REG_RCT_PERMANENT, 16'h0002));
    closing_plan.push_back(write_row(REG_APT_PERMANENT, 16'hffff));
    closing_plan.push_back(write_row(REG_APT_WINDOW, 16'hffff));
    closing_plan.push_back(item_row(ROW_REARM, 1'b0));
    closing_plan.push_back(item_row(ROW_SAMPLE, 1'b1));
    closing_plan.push_back(item_row(ROW_SAMPLE, 1'b1));
    closing_plan.push_back(item_row(ROW_SAMPLE, 1'b0));
    closing_plan.push_back(item_row(ROW_REARM, 1'b0));
    closing_plan.push_back(item_row(ROW_SAMPLE, 1'b1));

    // hold reset, then release it
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_plan[i])
      run_row(opening_plan[i]);

    // random phases, each under freshly drawn cutoffs
    for (phase = 0; phase < PHASES; phase++) begin
      write_reg(REG_RCT_TRANSIENT, draw_cutoff(2, 10));
      write_reg(REG_RCT_PERMANENT, draw_cutoff(4, 16));
      write_reg(REG_APT_TRANSIENT, draw_cutoff(2, 12));
      write_reg(REG_APT_PERMANENT, draw_cutoff(4, 16));
      write_reg(REG_APT_WINDOW, draw_cutoff(2, 20));
      if ($urandom_range(0, 3) == 0)
        write_reg(cfg_idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  CFG_W'($urandom));
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        style = $urandom_range(0, 99);
        if (style < 65) begin
          // a run of one value, often long enough to cross the run cutoffs
          b    = 1'($urandom_range(0, 1));
          span = $urandom_range(1, 12);
          repeat (span) offer_sample(b);
        end else if (style < 78) begin
          // alternating bits: runs stay short, windows see half matches
          b    = 1'($urandom_range(0, 1));
          span = $urandom_range(2, 16);
          repeat (span) begin
            offer_sample(b);
            b = !b;
          end
        end else if (style < 90) begin
          repeat ($urandom_range(1, 8)) offer_sample(1'($urandom_range(0, 1)));
        end else if (style < 97) begin
          send_item(OP_REARM, 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          // sender pause until every result is in
          settle_idle();
        end
      end
    end

    foreach (closing_plan[i])
      run_row(closing_plan[i]);

    settle_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && awaited_status.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
